// ===== sv/pd_pkg.sv =====
// Shared types, constants and helper functions for the percent decoder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package pd_pkg;

  // Character codes used by the decoder.
  localparam logic [7:0] PERCENT_CHAR = 8'h25;
  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_9 = 8'h39;
  localparam logic [7:0] CHAR_UA = 8'h41;
  localparam logic [7:0] CHAR_UF = 8'h46;
  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_LF = 8'h66;
  localparam logic [3:0] HEX_TEN = 4'd10;

  // Default depth of the job queue between front and back end.
  localparam int QUEUE_DEPTH = 4;

  // Input request payload.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  // Result payload.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       string_end;
  } out_t;

  // One job: the result bytes caused by a single input request.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      count;
    logic            last;
  } job_t;

  // What the front end currently holds back.
  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_PCT,
    HOLD_DIGIT
  } hold_t;

  // True for 0-9, A-F and a-f.
  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= CHAR_0 && c <= CHAR_9) || (c >= CHAR_UA && c <= CHAR_UF) ||
             (c >= CHAR_LA && c <= CHAR_LF);
  endfunction

  // Nibble value of a hex digit character.
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] low;
    low = c | 8'h20;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      hex_val = c[3:0];
    end else begin
      hex_val = 4'(low - CHAR_LA) + HEX_TEN;
    end
  endfunction

endpackage

`default_nettype wire

// ===== sv/pd_front.sv =====
// Front end of the percent decoder: tracks held escape bytes and turns each
// accepted request into a job of zero to three result bytes. Uses pd_pkg.
`default_nettype none

module pd_front
  import pd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic accept,
  input  wire in_t  in_data,
  output job_t      job,
  output logic      job_valid
);

  hold_t      state;
  hold_t      state_next;
  logic [7:0] first_hex_digit;
  logic [7:0] first_hex_digit_next;

  logic [7:0] b;
  logic       last;
  logic       hex;
  logic       starts_escape;

  assign b             = in_data.in_byte;
  assign last          = in_data.in_last;
  assign hex           = is_hex(b);
  assign starts_escape = (b == PERCENT_CHAR) && !last;

  // Next hold state and held digit.
  always_comb begin
    state_next           = HOLD_NONE;
    first_hex_digit_next = first_hex_digit;
    case (state)
      HOLD_PCT: begin
        if (hex && !last) begin
          state_next           = HOLD_DIGIT;
          first_hex_digit_next = b;
        end else if (starts_escape) begin
          state_next = HOLD_PCT;
        end
      end
      HOLD_DIGIT: begin
        if (!hex && starts_escape) begin
          state_next = HOLD_PCT;
        end
      end
      default: begin
        if (starts_escape) begin
          state_next = HOLD_PCT;
        end
      end
    endcase
  end

  // Result bytes for the current request.
  always_comb begin
    job.bytes = '0;
    job.count = 2'd0;
    job.last  = last;
    case (state)
      HOLD_PCT: begin
        if (!(hex && !last)) begin
          job.bytes[0] = PERCENT_CHAR;
          job.bytes[1] = b;
          job.count    = starts_escape ? 2'd1 : 2'd2;
        end
      end
      HOLD_DIGIT: begin
        if (hex) begin
          job.bytes[0] = {hex_val(first_hex_digit), hex_val(b)};
          job.count    = 2'd1;
        end else begin
          job.bytes[0] = PERCENT_CHAR;
          job.bytes[1] = first_hex_digit;
          job.bytes[2] = b;
          job.count    = starts_escape ? 2'd2 : 2'd3;
        end
      end
      default: begin
        job.bytes[0] = b;
        job.count    = starts_escape ? 2'd0 : 2'd1;
      end
    endcase
  end

  assign job_valid = accept && (job.count != 2'd0);

  // Hold state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= HOLD_NONE;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // Held digit; only read while the state says a digit is held.
  always_ff @(posedge clk) begin
    if (accept) begin
      first_hex_digit <= first_hex_digit_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/pd_queue.sv =====
// Small job queue that decouples the front end from the back end.
// Uses pd_pkg for the job type.
`default_nettype none

module pd_queue
  import pd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire job_t wr_job,
  input  wire logic rd_en,
  output job_t      rd_job,
  output logic      full,
  output logic      empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  job_t            mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full   = (count == CntFull);
  assign empty  = (count == '0);
  assign rd_job = mem[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PtrMax) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PtrMax) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/pd_emit.sv =====
// Back end of the percent decoder: loads the bytes of the oldest job one per
// cycle into the result register while it is empty or popped. Uses pd_pkg.
`default_nettype none

module pd_emit
  import pd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire job_t job,
  input  wire logic job_empty,
  output logic      job_pop,
  output out_t      out_data,
  output logic      out_valid,
  input  wire logic out_pop
);

  logic [1:0] idx;
  logic       load;
  logic       final_byte;

  assign load       = !job_empty && (!out_valid || out_pop);
  assign final_byte = (idx == job.count - 2'd1);
  assign job_pop    = load && final_byte;

  // Byte index within the current job.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (load) begin
      idx <= final_byte ? 2'd0 : idx + 2'd1;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_pop) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      out_data.out_byte   <= job.bytes[idx];
      out_data.run_end    <= final_byte;
      out_data.string_end <= final_byte && job.last;
    end
  end

endmodule

`default_nettype wire

// ===== sv/percent_decoder_core.sv =====
// Top level of the streaming URL percent decoder; instantiates pd_front,
// pd_queue and pd_emit, and uses pd_pkg for payload types and defaults.
`default_nettype none

// Percent decoder. Bytes of an encoded string enter through a queue-style
// port (push/full) and decoded bytes leave through another (empty/pop). A '%'
// followed by two hex digits becomes one byte; anything else, including a
// broken escape, passes through literally. The front end takes one request
// every cycle while the job queue (DEPTH entries) has room, and the back end
// delivers one result byte per cycle while results are taken, so plain text
// then flows at one byte per cycle. A broken escape that yields two or three
// bytes keeps the back end busy with each byte in turn; the queue absorbs
// this, and full rises only when such bursts outrun it or when results are
// not being taken. A request's first result passes through the job queue and
// the result register before it appears on the result ports. Requests that
// complete no byte (a held '%' or digit) yield no result. There is no
// clearing pass after reset.
module percent_decoder_core
  import pd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  output logic      full,
  input  wire in_t  in_data,
  output logic      empty,
  input  wire logic pop,
  output out_t      out_data
);

  job_t front_job;
  logic front_valid;
  job_t head_job;
  logic head_empty;
  logic head_pop;
  logic out_valid;
  logic accept;

  assign accept = push && !full;
  assign empty  = !out_valid;

  // Classify requests and track held escape bytes.
  pd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_data   (in_data),
    .job       (front_job),
    .job_valid (front_valid)
  );

  // Decoupling queue of jobs.
  pd_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (front_valid),
    .wr_job (front_job),
    .rd_en  (head_pop),
    .rd_job (head_job),
    .full   (full),
    .empty  (head_empty)
  );

  // Serialise job bytes into the result register.
  pd_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .job       (head_job),
    .job_empty (head_empty),
    .job_pop   (head_pop),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_pop   (pop)
  );

endmodule

`default_nettype wire

// ===== dv/percent_decoder_core_tb.sv =====
// Self-checking testbench for percent_decoder_core: directed and random strings,
// with its own decoder model, random idling on both sides and a long output stall.
// Depends on pd_pkg for the payload types, the hold states and the '%' code.
module percent_decoder_core_tb;
  import pd_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int STALL_LEN = 80;
  localparam int END_CYCLES = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  in_t in_data = '0;
  logic full;
  logic empty;
  out_t out_data;

  // Model state of the decoder and the decoded bytes still to arrive.
  hold_t esc_hold = HOLD_NONE;
  logic [7:0] esc_first = 8'h00;
  out_t run_q[$];
  out_t decoded_q[$];
  logic [7:0] text_q[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_epoch = 0;
  int err_cnt = 0;
  int sent_cnt = 0;
  int checked_cnt = 0;
  int escape_cnt = 0;
  int broken_cnt = 0;

  percent_decoder_core dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .in_data(in_data),
    .empty(empty),
    .pop(pop),
    .out_data(out_data)
  );

  initial forever #5 clk = ~clk;

  // Character classes used by the model.
  function automatic logic is_hex_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") begin
      return c[3:0];
    end
    return c[3:0] + 4'd9;
  endfunction

  function automatic void emit_byte(input logic [7:0] b);
    out_t r;
    r.out_byte = b;
    r.run_end = 1'b0;
    r.string_end = 1'b0;
    run_q.push_back(r);
  endfunction

  // A byte seen with nothing held: a '%' starts an escape unless the string ends.
  function automatic void take_plain(input logic [7:0] b, input logic l);
    if (b == PERCENT_CHAR && !l) begin
      esc_hold = HOLD_PCT;
    end else begin
      emit_byte(b);
    end
  endfunction

  // Works out the decoded bytes caused by one accepted request.
  function automatic void predict_decode(input in_t req);
    hold_t was;
    int idx;
    was = esc_hold;
    esc_hold = HOLD_NONE;
    run_q.delete();
    case (was)
      HOLD_PCT: begin
        if (is_hex_char(req.in_byte) && !req.in_last) begin
          esc_first = req.in_byte;
          esc_hold = HOLD_DIGIT;
        end else begin
          broken_cnt++;
          emit_byte(PERCENT_CHAR);
          take_plain(req.in_byte, req.in_last);
        end
      end
      HOLD_DIGIT: begin
        if (is_hex_char(req.in_byte)) begin
          escape_cnt++;
          emit_byte({nibble_of(esc_first), nibble_of(req.in_byte)});
        end else begin
          broken_cnt++;
          emit_byte(PERCENT_CHAR);
          emit_byte(esc_first);
          take_plain(req.in_byte, req.in_last);
        end
      end
      default: begin
        take_plain(req.in_byte, req.in_last);
      end
    endcase
    if (run_q.size() > 0) begin
      idx = run_q.size() - 1;
      run_q[idx].run_end = 1'b1;
      run_q[idx].string_end = req.in_last;
    end
    foreach (run_q[i]) decoded_q.push_back(run_q[i]);
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Result side: checks each result taken; result_pacing drives pop, long stall on request.
  always @(posedge clk) begin
    out_t want;
    if (!rst && pop && !empty) begin
      checked_cnt++;
      if (decoded_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none, actual byte %0h run_end %0b end %0b",
                 $time, out_data.out_byte, out_data.run_end, out_data.string_end);
      end else begin
        want = decoded_q.pop_front();
        check_field("out_byte", want.out_byte, out_data.out_byte);
        check_field("run_end", want.run_end, out_data.run_end);
        check_field("string_end", want.string_end, out_data.string_end);
      end
    end
  end

  initial begin : result_pacing
    int stall_seen;
    int stall_left;
    stall_seen = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_epoch != stall_seen) begin
        stall_seen = stall_epoch;
        stall_left = STALL_LEN;
      end
      if (rst || stall_left > 0) begin
        pop <= 1'b0;
        if (stall_left > 0) stall_left--;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Ends the run if nothing moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: nothing accepted for %0d cycles", $time, quiet);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offers one request, idling first at random, and holds it until it is taken.
  task automatic send_req(input logic [7:0] b, input logic l);
    in_t req;
    req.in_byte = b;
    req.in_last = l;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (full);
    predict_decode(req);
    sent_cnt++;
  endtask

  function automatic void add_byte(input logic [7:0] b);
    text_q.push_back(b);
  endfunction

  function automatic void add_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  // Sends the collected bytes, flagging the final one as the end of the string if asked.
  task automatic flush_text(input logic with_last);
    int n;
    n = text_q.size();
    for (int i = 0; i < n; i++) begin
      send_req(text_q[i], with_last && (i == n - 1));
    end
    text_q.delete();
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_hex_char();
    string digits;
    digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(21)];
  endfunction

  function automatic logic [7:0] rand_other_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (is_hex_char(c));
    return c;
  endfunction

  // One random string: mostly valid escapes and plain bytes, some broken escapes,
  // and now and then cut short so that an escape meets the end of the string.
  function automatic void build_random_string();
    int tokens;
    int kind;
    int keep;
    tokens = $urandom_range(6, 1);
    repeat (tokens) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        add_byte(8'($urandom_range(255)));
      end else if (kind < 75) begin
        add_byte(PERCENT_CHAR);
        add_byte(rand_hex_char());
        add_byte(rand_hex_char());
      end else if (kind < 85) begin
        add_byte(PERCENT_CHAR);
        add_byte(rand_hex_char());
        add_byte(rand_other_char());
      end else if (kind < 95) begin
        add_byte(PERCENT_CHAR);
        add_byte(rand_other_char());
      end else begin
        add_byte(PERCENT_CHAR);
      end
    end
    if ($urandom_range(3) == 0) begin
      keep = $urandom_range(text_q.size(), 1);
      while (text_q.size() > keep) void'(text_q.pop_back());
    end
  endfunction

  // Digit extremes, broken escapes, escapes cut by the end of the string, byte extremes.
  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_str("%0f%9A%aF");
    flush_text(1'b1);
    add_str("%:%F`%%41");
    flush_text(1'b1);
    add_str("%4");
    flush_text(1'b1);
    add_str("%4%");
    flush_text(1'b1);
    add_str("%");
    flush_text(1'b1);
    add_byte(8'h00);
    add_byte(8'hff);
    flush_text(1'b1);
    wait_drained();
  endtask

  task automatic test_random(input int snd_pct, input int rcv_pct, input int n_items);
    int start;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    start = sent_cnt;
    while (sent_cnt - start < n_items) begin
      build_random_string();
      flush_text(1'b1);
    end
    wait_drained();
  endtask

  // The result side stalls while broken escapes keep coming, so full must rise.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_epoch++;
    repeat (8) begin
      add_byte(PERCENT_CHAR);
      add_byte(rand_hex_char());
      add_byte(rand_other_char());
    end
    flush_text(1'b1);
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(32, 53, 100);
    test_random(53, 32, 100);
    test_random(0, 0, 80);
    test_backpressure();
    repeat (END_CYCLES) @(posedge clk);
    $display("Sent %0d requests; checked %0d decoded bytes, %0d from escapes.",
             sent_cnt, checked_cnt, escape_cnt);
    $display("Broken escapes passed through literally: %0d.", broken_cnt);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
